>>> rtl/pnsz_pkg.sv
// pnsz_pkg: constants, types and helpers for the polyline nearest segment z block
// no dependencies; imported by polyline_nearest_segment_z_interp
package pnsz_pkg;

    localparam int MAX_VERTICES = 256;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int CW           = 32;
    localparam int LW           = CW + 1;
    localparam int PW           = 2 * LW;
    localparam int NUM_W        = 4 * LW;
    localparam int ACC_W        = 200;
    localparam int QW           = 3 * LW;
    localparam int DCNT_W       = $clog2(QW + 1);
    localparam int QSAT_W       = 41;
    localparam int ZW           = CW + QSAT_W + 2;
    localparam int SEG_W        = 8;
    localparam int FUNC_W       = 2;
    localparam int STP_W        = 5;
    localparam int KW           = 3;

    typedef enum logic [FUNC_W-1:0] {
        FN_CLEAR  = 2'd0,
        FN_APPEND = 2'd1,
        FN_QUERY  = 2'd2
    } func_t;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_FETCH = 12'b0000_0000_0010,
        S_LATCH = 12'b0000_0000_0100,
        S_LEN   = 12'b0000_0000_1000,
        S_ALT   = 12'b0000_0001_0000,
        S_CRS   = 12'b0000_0010_0000,
        S_SQR   = 12'b0000_0100_0000,
        S_CMP   = 12'b0000_1000_0000,
        S_DOT   = 12'b0001_0000_0000,
        S_PROD  = 12'b0010_0000_0000,
        S_DIV   = 12'b0100_0000_0000,
        S_FIN   = 12'b1000_0000_0000
    } state_t;

    typedef struct packed {
        logic          vld;
        logic          clr;
        logic          neg;
        logic [KW-1:0] k;
    } mac_ctl_t;

    typedef struct packed {
        logic signed [CW-1:0] z;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] x;
    } vertex_t;

    function automatic logic signed [LW-1:0] diff33(input logic signed [CW-1:0] a,
                                                    input logic signed [CW-1:0] b);
        return LW'(a) - LW'(b);
    endfunction

    function automatic logic [LW-1:0] mag33(input logic signed [LW-1:0] v);
        return v[LW-1] ? LW'(-v) : LW'(v);
    endfunction

endpackage

>>> rtl/polyline_nearest_segment_z_interp.sv
// polyline_nearest_segment_z_interp: polyline store, nearest segment search, z interpolation
// depends on pnsz_pkg; vertex memory and shared 33x33 multiply-accumulate inside
// clear and append give no word; pass-through queries give their word in the cycle after start, busy stays low
// full query over n vertices: paced by the shared multiplier (up to 24 products per segment)
//   and the 99-step restoring divider
// no overlap, the receiver cannot stall; reset clears count and control, memory undefined
module polyline_nearest_segment_z_interp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [pnsz_pkg::FUNC_W-1:0]       func,
    input  logic signed [pnsz_pkg::CW-1:0]    px,
    input  logic signed [pnsz_pkg::CW-1:0]    py,
    input  logic signed [pnsz_pkg::CW-1:0]    pz,
    output logic                              busy,
    output logic                              done,
    output logic signed [pnsz_pkg::CW-1:0]    z_out,
    output logic [pnsz_pkg::SEG_W-1:0]        seg_index,
    output logic                              assigned
);
    import pnsz_pkg::*;

    localparam logic [QW-1:0] QLIM = QW'(64'd1 << 40);

    vertex_t mem [MAX_VERTICES];
    vertex_t rdata_reg;
    logic             wr_en, rd_en;
    logic [IDX_W-1:0] rd_addr;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [STP_W-1:0] stp_reg, stp_next;
    logic first_reg, first_next, final_reg, final_next;
    logic done_reg, done_next;
    mac_ctl_t ctl_reg, ctl_next;
    logic [DCNT_W-1:0] dcnt_reg, dcnt_next;

    logic signed [CW-1:0] qx_reg, qx_next, qy_reg, qy_next;
    logic signed [CW-1:0] bx_reg, bx_next, by_reg, by_next, bz_reg, bz_next;
    logic signed [CW-1:0] za_reg, za_next;
    logic [LW-1:0] dxm_reg, dxm_next, dym_reg, dym_next;
    logic [LW-1:0] exm_reg, exm_next, eym_reg, eym_next, dzm_reg, dzm_next;
    logic sdx_reg, sdx_next, sdy_reg, sdy_next, sex_reg, sex_next;
    logic sey_reg, sey_next, sdz_reg, sdz_next;
    logic [IDX_W-1:0] fidx_reg, fidx_next, seg_reg, seg_next, best_reg, best_next;
    logic [PW-1:0] len2_reg, len2_next, wmag_reg, wmag_next, den_reg, den_next;
    logic [PW-1:0] bd_reg, bd_next;
    logic [NUM_W-1:0] num_reg, num_next, bn_reg, bn_next;
    logic [PW-1:0] prod_reg, prod_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [PW-1:0] rem_reg, rem_next;
    logic [QW-1:0] quo_reg, quo_next;
    logic signed [CW-1:0] z_reg, z_next;
    logic [SEG_W-1:0] sego_reg, sego_next;
    logic asg_reg, asg_next;

    logic [LW-1:0] mul_a, mul_b;
    logic signed [LW-1:0] dx_w, dy_w, ex_w, ey_w, dz_w;
    logic [ACC_W-1:0] acc_mag, acc_term, acc_base;
    logic [1:0] ni;
    logic di, adv;
    logic [PW:0] rem_sh;
    logic [QSAT_W-1:0] qsat_w;
    logic signed [ZW-1:0] za_ext, q_ext, zsum;
    logic signed [CW-1:0] zsat;

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign z_out     = z_reg;
    assign seg_index = sego_reg;
    assign assigned  = asg_reg;

    assign dx_w = diff33(rdata_reg.x, bx_reg);
    assign dy_w = diff33(rdata_reg.y, by_reg);
    assign ex_w = diff33(qx_reg, bx_reg);
    assign ey_w = diff33(qy_reg, by_reg);
    assign dz_w = diff33(rdata_reg.z, bz_reg);

    assign acc_mag  = acc_reg[ACC_W-1] ? (~acc_reg + ACC_W'(1)) : acc_reg;
    assign ni       = stp_reg[2:1];
    assign di       = stp_reg[0];
    assign rem_sh   = {rem_reg, quo_reg[QW-1]};
    assign prod_next = mul_a * mul_b;

    assign acc_term = ACC_W'(prod_reg) << (LW * ctl_reg.k);
    assign acc_base = ctl_reg.clr ? '0 : acc_reg;
    assign acc_next = !ctl_reg.vld ? acc_reg
                    : (ctl_reg.neg ? acc_base - acc_term : acc_base + acc_term);

    assign qsat_w = (quo_reg > QLIM) ? QSAT_W'(QLIM) : quo_reg[QSAT_W-1:0];
    assign za_ext = ZW'(za_reg);
    assign q_ext  = signed'(ZW'(qsat_w));
    assign zsum   = sdz_reg ? za_ext - q_ext : za_ext + q_ext;
    assign zsat   = (zsum[ZW-1:CW-1] == '0 || zsum[ZW-1:CW-1] == '1) ? zsum[CW-1:0]
                  : (zsum[ZW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}});

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[cnt_reg[IDX_W-1:0]] <= '{z: pz, y: py, x: px};
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        stp_next   = stp_reg;
        first_next = first_reg;
        final_next = final_reg;
        done_next  = 1'b0;
        dcnt_next  = dcnt_reg;
        ctl_next   = '0;
        mul_a      = '0;
        mul_b      = '0;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = fidx_reg;
        adv        = 1'b0;
        qx_next = qx_reg;   qy_next = qy_reg;
        bx_next = bx_reg;   by_next = by_reg;   bz_next = bz_reg;   za_next = za_reg;
        dxm_next = dxm_reg; dym_next = dym_reg; exm_next = exm_reg; eym_next = eym_reg;
        dzm_next = dzm_reg;
        sdx_next = sdx_reg; sdy_next = sdy_reg; sex_next = sex_reg; sey_next = sey_reg;
        sdz_next = sdz_reg;
        fidx_next = fidx_reg; seg_next = seg_reg; best_next = best_reg;
        len2_next = len2_reg; wmag_next = wmag_reg; den_next = den_reg; bd_next = bd_reg;
        num_next = num_reg; bn_next = bn_reg;
        rem_next = rem_reg; quo_next = quo_reg;
        z_next = z_reg; sego_next = sego_reg; asg_next = asg_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (func_t'(func))
                        FN_CLEAR:
                        begin
                            cnt_next = '0;
                        end
                        FN_APPEND:
                        begin
                            if (cnt_reg < CNT_W'(MAX_VERTICES))
                            begin
                                wr_en    = 1'b1;
                                cnt_next = cnt_reg + CNT_W'(1);
                            end
                        end
                        FN_QUERY:
                        begin
                            qx_next = px;
                            qy_next = py;
                            if (pz != '0 || cnt_reg <= CNT_W'(2))
                            begin
                                done_next = 1'b1;
                                z_next    = pz;
                                sego_next = '0;
                                asg_next  = 1'b0;
                            end
                            else
                            begin
                                fidx_next  = '0;
                                seg_next   = '0;
                                best_next  = '0;
                                first_next = 1'b1;
                                final_next = 1'b0;
                                state_next = S_FETCH;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_FETCH:
            begin
                rd_en      = 1'b1;
                state_next = S_LATCH;
            end
            S_LATCH:
            begin
                bx_next = rdata_reg.x;
                by_next = rdata_reg.y;
                bz_next = rdata_reg.z;
                if (first_reg)
                begin
                    first_next = 1'b0;
                    fidx_next  = fidx_reg + IDX_W'(1);
                    state_next = S_FETCH;
                end
                else
                begin
                    za_next  = bz_reg;
                    dxm_next = mag33(dx_w); sdx_next = dx_w[LW-1];
                    dym_next = mag33(dy_w); sdy_next = dy_w[LW-1];
                    exm_next = mag33(ex_w); sex_next = ex_w[LW-1];
                    eym_next = mag33(ey_w); sey_next = ey_w[LW-1];
                    dzm_next = mag33(dz_w); sdz_next = dz_w[LW-1];
                    stp_next   = '0;
                    state_next = S_LEN;
                end
            end
            S_LEN:
            begin
                ctl_next.vld = (stp_reg < STP_W'(2));
                ctl_next.clr = (stp_reg == '0);
                mul_a = stp_reg[0] ? dym_reg : dxm_reg;
                mul_b = mul_a;
                stp_next = stp_reg + STP_W'(1);
                if (stp_reg == STP_W'(3))
                begin
                    stp_next  = '0;
                    len2_next = acc_reg[PW-1:0];
                    if (final_reg)
                    begin
                        if (acc_reg[PW-1:0] == '0)
                        begin
                            done_next  = 1'b1;
                            z_next     = za_reg;
                            sego_next  = SEG_W'(best_reg);
                            asg_next   = 1'b0;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_DOT;
                        end
                    end
                    else
                    begin
                        state_next = (acc_reg[PW-1:0] == '0) ? S_ALT : S_CRS;
                    end
                end
            end
            S_ALT:
            begin
                ctl_next.vld = (stp_reg < STP_W'(2));
                ctl_next.clr = (stp_reg == '0);
                mul_a = stp_reg[0] ? eym_reg : exm_reg;
                mul_b = mul_a;
                stp_next = stp_reg + STP_W'(1);
                if (stp_reg == STP_W'(3))
                begin
                    stp_next = '0;
                    num_next = NUM_W'(acc_reg[PW-1:0]);
                    den_next = PW'(1);
                    if (seg_reg == '0)
                    begin
                        bn_next = num_next;
                        bd_next = den_next;
                        adv     = 1'b1;
                    end
                    else
                    begin
                        state_next = S_CMP;
                    end
                end
            end
            S_CRS:
            begin
                ctl_next.vld = (stp_reg < STP_W'(2));
                ctl_next.clr = (stp_reg == '0);
                ctl_next.neg = stp_reg[0] ? !(sdy_reg ^ sex_reg) : (sdx_reg ^ sey_reg);
                mul_a = stp_reg[0] ? dym_reg : dxm_reg;
                mul_b = stp_reg[0] ? exm_reg : eym_reg;
                stp_next = stp_reg + STP_W'(1);
                if (stp_reg == STP_W'(3))
                begin
                    stp_next   = '0;
                    wmag_next  = acc_mag[PW-1:0];
                    state_next = S_SQR;
                end
            end
            S_SQR:
            begin
                ctl_next.vld = (stp_reg < STP_W'(4));
                ctl_next.clr = (stp_reg == '0);
                ctl_next.k   = KW'(stp_reg[0]) + KW'(stp_reg[1]);
                mul_a = stp_reg[1] ? wmag_reg[PW-1:LW] : wmag_reg[LW-1:0];
                mul_b = stp_reg[0] ? wmag_reg[PW-1:LW] : wmag_reg[LW-1:0];
                stp_next = stp_reg + STP_W'(1);
                if (stp_reg == STP_W'(5))
                begin
                    stp_next = '0;
                    num_next = acc_reg[NUM_W-1:0];
                    den_next = len2_reg;
                    if (seg_reg == '0)
                    begin
                        bn_next = num_next;
                        bd_next = den_next;
                        adv     = 1'b1;
                    end
                    else
                    begin
                        state_next = S_CMP;
                    end
                end
            end
            S_CMP:
            begin
                ctl_next.vld = (stp_reg < STP_W'(16));
                ctl_next.clr = (stp_reg == '0);
                ctl_next.neg = stp_reg[3];
                ctl_next.k   = KW'(ni) + KW'(di);
                mul_a = stp_reg[3] ? bn_reg[LW*ni +: LW] : num_reg[LW*ni +: LW];
                mul_b = stp_reg[3] ? den_reg[LW*di +: LW] : bd_reg[LW*di +: LW];
                stp_next = stp_reg + STP_W'(1);
                if (stp_reg == STP_W'(17))
                begin
                    stp_next = '0;
                    if (acc_reg[ACC_W-1])
                    begin
                        bn_next   = num_reg;
                        bd_next   = den_reg;
                        best_next = seg_reg;
                    end
                    adv = 1'b1;
                end
            end
            S_DOT:
            begin
                ctl_next.vld = (stp_reg < STP_W'(2));
                ctl_next.clr = (stp_reg == '0);
                ctl_next.neg = stp_reg[0] ? (sdy_reg ^ sey_reg) : (sdx_reg ^ sex_reg);
                mul_a = stp_reg[0] ? dym_reg : dxm_reg;
                mul_b = stp_reg[0] ? eym_reg : exm_reg;
                stp_next = stp_reg + STP_W'(1);
                if (stp_reg == STP_W'(3))
                begin
                    stp_next   = '0;
                    wmag_next  = acc_mag[PW-1:0];
                    state_next = S_PROD;
                end
            end
            S_PROD:
            begin
                ctl_next.vld = (stp_reg < STP_W'(2));
                ctl_next.clr = (stp_reg == '0);
                ctl_next.k   = KW'(stp_reg[0]);
                mul_a = stp_reg[0] ? wmag_reg[PW-1:LW] : wmag_reg[LW-1:0];
                mul_b = dzm_reg;
                stp_next = stp_reg + STP_W'(1);
                if (stp_reg == STP_W'(3))
                begin
                    stp_next   = '0;
                    quo_next   = acc_reg[QW-1:0];
                    rem_next   = '0;
                    dcnt_next  = DCNT_W'(QW);
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                quo_next = {quo_reg[QW-2:0], 1'b0};
                if (rem_sh >= {1'b0, len2_reg})
                begin
                    rem_next    = PW'(rem_sh - {1'b0, len2_reg});
                    quo_next[0] = 1'b1;
                end
                else
                begin
                    rem_next = PW'(rem_sh);
                end
                dcnt_next = dcnt_reg - DCNT_W'(1);
                if (dcnt_reg == DCNT_W'(1))
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                done_next  = 1'b1;
                z_next     = zsat;
                sego_next  = SEG_W'(best_reg);
                asg_next   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (adv)
        begin
            if ((CNT_W'(seg_reg) + CNT_W'(2)) < cnt_reg)
            begin
                seg_next  = seg_reg + IDX_W'(1);
                fidx_next = seg_reg + IDX_W'(2);
            end
            else
            begin
                final_next = 1'b1;
                first_next = 1'b1;
                fidx_next  = best_next;
            end
            state_next = S_FETCH;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            stp_reg   <= '0;
            first_reg <= 1'b0;
            final_reg <= 1'b0;
            done_reg  <= 1'b0;
            ctl_reg   <= '0;
            dcnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            stp_reg   <= stp_next;
            first_reg <= first_next;
            final_reg <= final_next;
            done_reg  <= done_next;
            ctl_reg   <= ctl_next;
            dcnt_reg  <= dcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qx_reg <= qx_next;   qy_reg <= qy_next;
        bx_reg <= bx_next;   by_reg <= by_next;   bz_reg <= bz_next;   za_reg <= za_next;
        dxm_reg <= dxm_next; dym_reg <= dym_next; exm_reg <= exm_next; eym_reg <= eym_next;
        dzm_reg <= dzm_next;
        sdx_reg <= sdx_next; sdy_reg <= sdy_next; sex_reg <= sex_next; sey_reg <= sey_next;
        sdz_reg <= sdz_next;
        fidx_reg <= fidx_next; seg_reg <= seg_next; best_reg <= best_next;
        len2_reg <= len2_next; wmag_reg <= wmag_next; den_reg <= den_next; bd_reg <= bd_next;
        num_reg <= num_next; bn_reg <= bn_next;
        prod_reg <= prod_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next; quo_reg <= quo_next;
        z_reg <= z_next; sego_reg <= sego_next; asg_reg <= asg_next;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_VERTICES))
        else $error("vertex count above capacity");

    a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> dcnt_reg != '0)
        else $error("divider step count ran out");

    a_cmp_seg: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CMP |-> seg_reg != '0 && (CNT_W'(seg_reg) + CNT_W'(1)) < cnt_reg)
        else $error("compare on first or missing segment");

    a_assigned_src: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && asg_reg |-> $past(state_reg) == S_FIN)
        else $error("interpolated word not from final step");

endmodule

>>> tb/tb_polyline_nearest_segment_z_interp.sv
// testbench for polyline_nearest_segment_z_interp: queue-fed driver, clocked monitor
// and an exact wide-integer predictor of the nearest segment z interpolation
// depends on pnsz_pkg and the block itself
`timescale 1ns / 100ps

module tb_polyline_nearest_segment_z_interp;
    import pnsz_pkg::*;

    localparam logic [FUNC_W-1:0] FN_SPARE = 2'd3;

    typedef struct {
        logic [FUNC_W-1:0]    f;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        bit                   hold;
    } word_t;

    typedef struct {
        logic signed [CW-1:0] z;
        logic [SEG_W-1:0]     seg;
        logic                 asg;
    } zres_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic [FUNC_W-1:0]    func;
    logic signed [CW-1:0] px, py, pz;
    logic                 busy, done;
    logic signed [CW-1:0] z_out;
    logic [SEG_W-1:0]     seg_index;
    logic                 assigned;

    word_t pending_words[$];
    zres_t expected_z[$];
    logic signed [CW-1:0] line_x[MAX_VERTICES];
    logic signed [CW-1:0] line_y[MAX_VERTICES];
    logic signed [CW-1:0] line_z[MAX_VERTICES];
    int vert_total;
    int taken;
    int errors;

    polyline_nearest_segment_z_interp i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .func(func), .px(px), .py(py), .pz(pz),
        .busy(busy), .done(done), .z_out(z_out), .seg_index(seg_index), .assigned(assigned)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic logic [255:0] mag(input logic signed [127:0] v);
        return v < 0 ? 256'(-v) : 256'(v);
    endfunction

    task automatic apply_word(input word_t w);
        logic signed [127:0] dx, dy, ex, ey, cr, dot, dz, za, zr, qs;
        logic [255:0] len2, num, den, bn, bd, q;
        int best;
        zres_t r;
        best = 0;
        bn = '0;
        bd = 256'd1;
        if (w.f == FN_CLEAR)
            vert_total = 0;
        else if (w.f == FN_APPEND)
        begin
            if (vert_total < MAX_VERTICES)
            begin
                line_x[vert_total] = w.x;
                line_y[vert_total] = w.y;
                line_z[vert_total] = w.z;
                vert_total++;
            end
        end
        else if (w.f == FN_QUERY)
        begin
            r.z = w.z;
            r.seg = '0;
            r.asg = 1'b0;
            if (w.z == 0 && vert_total > 2)
            begin
                for (int i = 0; i + 1 < vert_total; i++)
                begin
                    dx = line_x[i+1] - line_x[i];
                    dy = line_y[i+1] - line_y[i];
                    ex = w.x - line_x[i];
                    ey = w.y - line_y[i];
                    len2 = mag(dx * dx + dy * dy);
                    if (len2 == 0)
                    begin
                        num = mag(ex * ex + ey * ey);
                        den = 256'd1;
                    end
                    else
                    begin
                        cr = dx * ey - dy * ex;
                        num = mag(cr) * mag(cr);
                        den = len2;
                    end
                    if (i == 0 || num * bd < bn * den)
                    begin
                        bn = num;
                        bd = den;
                        best = i;
                    end
                end
                dx = line_x[best+1] - line_x[best];
                dy = line_y[best+1] - line_y[best];
                ex = w.x - line_x[best];
                ey = w.y - line_y[best];
                za = line_z[best];
                dz = line_z[best+1] - line_z[best];
                len2 = mag(dx * dx + dy * dy);
                zr = za;
                if (len2 != 0)
                begin
                    dot = dx * ex + dy * ey;
                    q = (mag(dot) * mag(dz)) / len2;
                    if (q > (256'd1 << 40))
                        q = 256'd1 << 40;
                    qs = q[127:0];
                    zr = dz < 0 ? za - qs : za + qs;
                    if (zr > 128'sd2147483647)
                        zr = 128'sd2147483647;
                    if (zr < -128'sd2147483648)
                        zr = -128'sd2147483648;
                    r.asg = 1'b1;
                end
                r.z = zr[CW-1:0];
                r.seg = best[SEG_W-1:0];
            end
            expected_z.insert(expected_z.size(), r);
        end
    endtask

    // driver
    always @(negedge clk)
    begin
        int idle_pct;
        idle_pct = taken < 600 ? 13 : (taken < 1200 ? 79 : 0);
        if (!rst_n || pending_words.size() == 0)
            start <= 1'b0;
        else if (pending_words[0].hold)
        begin
            start <= 1'b0;
            if (expected_z.size() == 0 && !busy)
                void'(pending_words.pop_front());
        end
        else if ($urandom_range(0, 99) >= idle_pct)
        begin
            start <= 1'b1;
            func <= pending_words[0].f;
            px <= pending_words[0].x;
            py <= pending_words[0].y;
            pz <= pending_words[0].z;
        end
        else
            start <= 1'b0;
    end

    // acceptance and monitor
    always @(posedge clk)
    begin
        zres_t e;
        if (rst_n && start && !busy && pending_words.size() > 0)
        begin
            apply_word(pending_words.pop_front());
            taken++;
        end
        if (rst_n && done)
        begin
            if (expected_z.size() == 0)
            begin
                $display("%0t: unexpected word z=%0d seg=%0d asg=%0b", $time, z_out,
                         seg_index, assigned);
                errors++;
            end
            else
            begin
                e = expected_z.pop_front();
                if (z_out !== e.z)
                begin
                    $display("%0t: z_out expected %0d actual %0d", $time, e.z, z_out);
                    errors++;
                end
                if (seg_index !== e.seg)
                begin
                    $display("%0t: seg_index expected %0d actual %0d", $time, e.seg, seg_index);
                    errors++;
                end
                if (assigned !== e.asg)
                begin
                    $display("%0t: assigned expected %0b actual %0b", $time, e.asg, assigned);
                    errors++;
                end
            end
        end
    end

    task automatic add(input logic [FUNC_W-1:0] f, input logic signed [CW-1:0] x,
                       input logic signed [CW-1:0] y, input logic signed [CW-1:0] z);
        word_t w;
        w.f = f;
        w.x = x;
        w.y = y;
        w.z = z;
        w.hold = 1'b0;
        pending_words.insert(pending_words.size(), w);
    endtask

    task automatic add_hold();
        word_t w;
        w.f = FN_CLEAR;
        w.x = 0;
        w.y = 0;
        w.z = 0;
        w.hold = 1'b1;
        pending_words.insert(pending_words.size(), w);
    endtask

    function automatic logic signed [CW-1:0] coord(input int mode);
        case (mode)
            0: return $urandom_range(0, 16) - 8;
            1: return $urandom_range(0, 2000) - 1000;
            2: return $urandom_range(0, 3) == 0 ? ($urandom_range(0, 1) ? 32'h7fffffff
                                                                      : 32'h80000000)
                                                : $urandom;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int mode, n, total;
        start = 1'b0;
        func = FN_CLEAR;
        px = 0;
        py = 0;
        pz = 0;
        vert_total = 0;
        taken = 0;
        errors = 0;
        rst_n = 1'b0;

        // directed part
        add(FN_QUERY, 5, 5, 0);
        add(FN_APPEND, 0, 0, 100);
        add(FN_APPEND, 10, 0, 200);
        add(FN_QUERY, 3, 1, 0);
        add(FN_APPEND, 10, 0, 300);
        add(FN_APPEND, 10, 10, -400);
        add(FN_QUERY, 4, 3, 0);
        add(FN_QUERY, 10, 0, 0);
        add(FN_QUERY, 12, 5, 0);
        add(FN_QUERY, 4, 3, 77);
        add(FN_SPARE, 32'hffffffff, 32'hffffffff, 32'hffffffff);
        add(FN_QUERY, 32'h7fffffff, 32'h80000000, 0);
        add(FN_CLEAR, 0, 0, 0);
        add(FN_APPEND, 0, 0, 32'h80000000);
        add(FN_APPEND, 1, 0, 32'h7fffffff);
        add(FN_APPEND, 1, 1, 32'h80000000);
        add(FN_QUERY, 32'h7fffffff, 32'h7fffffff, 0);
        add(FN_QUERY, 32'h80000000, 32'h80000000, 0);
        add(FN_CLEAR, 0, 0, 0);
        add(FN_APPEND, 32'h80000000, 32'h80000000, 32'h7fffffff);
        add(FN_APPEND, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
        add(FN_APPEND, 32'h80000000, 32'h7fffffff, 1);
        add(FN_QUERY, 0, 0, 0);
        add(FN_QUERY, 32'h7fffffff, 32'h80000000, 0);
        add_hold();

        // random part
        total = 0;
        while (total < 1700)
        begin
            if ($urandom_range(0, 99) < 15)
            begin
                add(FUNC_W'($urandom_range(0, 3)), $urandom, $urandom,
                    $urandom_range(0, 1) ? 0 : $urandom);
                total++;
            end
            else
            begin
                mode = $urandom_range(0, 3);
                n = $urandom_range(0, 9) == 0 ? $urandom_range(0, 2) : $urandom_range(3, 12);
                if (total > 600 && total < 640 || total > 1300 && total < 1340)
                    n = MAX_VERTICES + 2;
                add(FN_CLEAR, $urandom, $urandom, $urandom);
                for (int i = 0; i < n; i++)
                    add(FN_APPEND, coord(mode), coord(mode), $urandom_range(0, 1) ? coord(2)
                                                                       : coord(1));
                for (int i = $urandom_range(1, 4); i > 0; i--)
                begin
                    add(FN_QUERY, coord($urandom_range(0, 1) ? mode : 3), coord(mode),
                        $urandom_range(0, 5) == 0 ? coord(3) : 0);
                    total++;
                end
                total += n + 1;
            end
            if ($urandom_range(0, 40) == 0)
                add_hold();
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (pending_words.size() == 0);
        wait (expected_z.size() == 0 && !busy);
        repeat (60) @(posedge clk);
        if (errors == 0 && expected_z.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #400_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
